// ===== rtl/bpfa_pkg.sv =====
// Package: shared types, codes and constants of the bitmap page-frame allocator.
package bpfa_pkg;

    localparam int FRAMES_DEF     = 4096;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int WORD_BITS_DEF  = 32;

    localparam int FCW        = 22;
    localparam int CFG_W      = 13;
    localparam int ADDR_W     = 24;
    localparam int SIZE_W     = 25;
    localparam int CFG_RESET  = 4096;

    typedef enum logic [1:0] {
        CMD_ALLOC_ANY = 2'd0,
        CMD_ALLOC_AT  = 2'd1,
        CMD_FREE      = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_ROOM  = 2'd1,
        STAT_USED     = 2'd2,
        STAT_WAS_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_MARK,
        ST_FREE
    } state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] frame_address;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_address;
    } rsp_t;

endpackage

// ===== rtl/bpfa_bitmap_ram.sv =====
// Bitmap word memory: one write port, one registered read port.
module bpfa_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int W     = 32,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bpfa_run_scan.sv =====
// Free-run evaluation of one bitmap word against the carried run length.
module bpfa_run_scan #(
    parameter int W  = 32,
    parameter int IW = 5
) (
    input  logic [W-1:0]               used,
    input  logic [bpfa_pkg::FCW-1:0]   run_in,
    input  logic [bpfa_pkg::FCW-1:0]   pages,
    output logic                       found,
    output logic [IW-1:0]              idx,
    output logic                       used_before,
    output logic                       has_used,
    output logic [IW-1:0]              last_used,
    output logic [bpfa_pkg::FCW-1:0]   run_out
);

    logic [W-1:0]                   lu_found;
    logic [IW-1:0]                  lu_pos [W];
    logic [bpfa_pkg::FCW-1:0]       run_at [W];
    logic [W-1:0]                   hit;

    always_comb
    begin
        for (int j = 0; j < W; j++)
        begin
            lu_found[j] = 1'b0;
            lu_pos[j]   = '0;
            for (int k = 0; k <= j; k++)
            begin
                if (used[k])
                begin
                    lu_found[j] = 1'b1;
                    lu_pos[j]   = IW'(k);
                end
            end
            if (lu_found[j])
                run_at[j] = bpfa_pkg::FCW'(IW'(j) - lu_pos[j]);
            else
                run_at[j] = run_in + bpfa_pkg::FCW'(j + 1);
            hit[j] = (run_at[j] >= pages);
        end
    end

    always_comb
    begin
        found       = 1'b0;
        idx         = '0;
        used_before = 1'b0;
        for (int j = W - 1; j >= 0; j--)
        begin
            if (hit[j])
            begin
                found       = 1'b1;
                idx         = IW'(j);
                used_before = lu_found[j];
            end
        end
    end

    assign has_used  = lu_found[W-1];
    assign last_used = lu_pos[W-1];
    assign run_out   = run_at[W-1];

endmodule

// ===== rtl/bitmap_page_frame_allocator_unit.sv =====
// Top level: command sequencer of the bitmap page-frame allocator.
//
// Commands enter on req when start is high and busy is low; each command gives
// exactly one result on rsp, shown for one cycle with done high. The receiver
// cannot hold results off. frame_count is written on the cfg channel
// (cfg_valid/cfg_ready/cfg_data); the user must write it only while no
// command is in flight, and the block itself does not enforce it.
// Steps per command, W = WORD_BITS, N = effective frame count:
//   zero-page, out-of-range and unknown commands: answered from idle.
//   allocate-any: reads words from word 0 (up to ceil(N/W)) until a run is
//     found, then reads and marks each word of the run.
//   allocate-at: checks each word from word 0 to the run's end, then marks
//     each word of the run.
//   free: reads each word from word 0 to the frame's word, then clears its bit.
// The bitmap sits in a one-port-read, one-port-write word memory.
// After reset busy stays high while every word is set to all used; the
// frame count resets to 4096.
module bitmap_page_frame_allocator_unit #(
    parameter int FRAMES     = bpfa_pkg::FRAMES_DEF,
    parameter int PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF,
    parameter int WORD_BITS  = bpfa_pkg::WORD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  bpfa_pkg::req_t             req,
    output logic                       done,
    output bpfa_pkg::rsp_t             rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bpfa_pkg::CFG_W-1:0] cfg_data
);

    localparam int W   = WORD_BITS;
    localparam int WC  = (FRAMES + W - 1) / W;
    localparam int AW  = (WC > 1) ? $clog2(WC) : 1;
    localparam int IW  = $clog2(W);
    localparam int FCW = bpfa_pkg::FCW;
    localparam int AD  = bpfa_pkg::ADDR_W;
    localparam int SIZE_SUM_W = bpfa_pkg::SIZE_W + 1;

    bpfa_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    cur_w_reg, cur_w_next;
    logic [FCW-1:0]   base_reg, base_next;
    logic [FCW-1:0]   run_reg, run_next;
    logic [AW-1:0]    rsw_reg, rsw_next;
    logic [FCW-1:0]   rsw_base_reg, rsw_base_next;
    logic [FCW-1:0]   s_reg, s_next;
    logic [FCW-1:0]   e_reg, e_next;
    logic [FCW-1:0]   pages_reg, pages_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [bpfa_pkg::CFG_W-1:0] frame_count_reg;
    logic             done_reg, done_next;
    bpfa_pkg::rsp_t   rsp_reg, rsp_next;

    logic             we, re;
    logic [AW-1:0]    waddr;
    logic [W-1:0]     wdata, rd_data;

    logic [FCW-1:0]   cnt, pages_in, pfn, base_end, start_frame;
    logic [SIZE_SUM_W-1:0] size_sum;
    logic [W-1:0]     rng_mask, used_word;
    logic [FCW+PAGE_SHIFT-1:0] s_wide;
    logic [AD-1:0]    aligned_addr;
    logic             s_in_word;

    logic             sc_found, sc_used_before, sc_has_used;
    logic [IW-1:0]    sc_idx, sc_last_used;
    logic [FCW-1:0]   sc_run_out;

    assign cnt = (FCW'(frame_count_reg) < FCW'(FRAMES)) ? FCW'(frame_count_reg)
                                                         : FCW'(FRAMES);
    assign size_sum = SIZE_SUM_W'(req.size_bytes) + SIZE_SUM_W'((1 << PAGE_SHIFT) - 1);
    assign pages_in = FCW'(size_sum >> PAGE_SHIFT);
    assign pfn      = FCW'(req.frame_address >> PAGE_SHIFT);
    assign aligned_addr = (req.frame_address >> PAGE_SHIFT) << PAGE_SHIFT;
    assign base_end = base_reg + FCW'(W);
    assign s_in_word = (s_reg >= base_reg) && (s_reg < base_end);
    assign start_frame = base_reg + FCW'(sc_idx) + FCW'(1) - pages_reg;
    assign s_wide  = {s_reg, {PAGE_SHIFT{1'b0}}};

    always_comb
    begin
        for (int j = 0; j < W; j++)
        begin
            rng_mask[j]  = ((base_reg + FCW'(j)) >= s_reg) && ((base_reg + FCW'(j)) < e_reg);
            used_word[j] = rd_data[j] || ((base_reg + FCW'(j)) >= cnt);
        end
    end

    bpfa_bitmap_ram #(
        .DEPTH (WC),
        .W     (W),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (cur_w_next),
        .rdata (rd_data)
    );

    bpfa_run_scan #(
        .W  (W),
        .IW (IW)
    ) u_scan (
        .used        (used_word),
        .run_in      (run_reg),
        .pages       (pages_reg),
        .found       (sc_found),
        .idx         (sc_idx),
        .used_before (sc_used_before),
        .has_used    (sc_has_used),
        .last_used   (sc_last_used),
        .run_out     (sc_run_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bpfa_pkg::ST_CLEAR;
            clr_reg         <= '0;
            done_reg        <= 1'b0;
            frame_count_reg <= bpfa_pkg::CFG_W'(bpfa_pkg::CFG_RESET);
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                frame_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_w_reg    <= cur_w_next;
        base_reg     <= base_next;
        run_reg      <= run_next;
        rsw_reg      <= rsw_next;
        rsw_base_reg <= rsw_base_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        pages_reg    <= pages_next;
        rsp_reg      <= rsp_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cur_w_next    = cur_w_reg;
        base_next     = base_reg;
        run_next      = run_reg;
        rsw_next      = rsw_reg;
        rsw_base_next = rsw_base_reg;
        s_next        = s_reg;
        e_next        = e_reg;
        pages_next    = pages_reg;
        clr_next      = clr_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        we            = 1'b0;
        waddr         = cur_w_reg;
        wdata         = '0;
        re            = 1'b0;

        unique case (state_reg)
            bpfa_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = '1;
                if (clr_reg == AW'(WC - 1))
                    state_next = bpfa_pkg::ST_IDLE;
                else
                    clr_next = clr_reg + AW'(1);
            end
            bpfa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cur_w_next    = '0;
                    base_next     = '0;
                    run_next      = '0;
                    rsw_next      = '0;
                    rsw_base_next = '0;
                    pages_next    = pages_in;
                    done_next     = 1'b1;
                    rsp_next      = '{status: bpfa_pkg::STAT_NO_ROOM, result_address: '0};
                    unique case (req.cmd)
                        bpfa_pkg::CMD_ALLOC_ANY:
                        begin
                            if (pages_in == '0)
                                rsp_next.status = bpfa_pkg::STAT_OK;
                            else if (cnt != '0)
                            begin
                                done_next  = 1'b0;
                                re         = 1'b1;
                                state_next = bpfa_pkg::ST_SEARCH;
                            end
                        end
                        bpfa_pkg::CMD_ALLOC_AT:
                        begin
                            if (pages_in == '0)
                            begin
                                rsp_next.status         = bpfa_pkg::STAT_OK;
                                rsp_next.result_address = aligned_addr;
                            end
                            else if (pfn + pages_in <= cnt)
                            begin
                                done_next  = 1'b0;
                                re         = 1'b1;
                                s_next     = pfn;
                                e_next     = pfn + pages_in;
                                state_next = bpfa_pkg::ST_CHECK;
                            end
                        end
                        bpfa_pkg::CMD_FREE:
                        begin
                            if (pfn < cnt)
                            begin
                                done_next  = 1'b0;
                                re         = 1'b1;
                                s_next     = pfn;
                                e_next     = pfn + FCW'(1);
                                state_next = bpfa_pkg::ST_FREE;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = bpfa_pkg::STAT_NO_ROOM;
                        end
                    endcase
                end
            end
            bpfa_pkg::ST_SEARCH:
            begin
                if (sc_found)
                begin
                    s_next     = start_frame;
                    e_next     = start_frame + pages_reg;
                    cur_w_next = sc_used_before ? cur_w_reg : rsw_reg;
                    base_next  = sc_used_before ? base_reg : rsw_base_reg;
                    re         = 1'b1;
                    state_next = bpfa_pkg::ST_MARK;
                end
                else if (base_end >= cnt)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{status: bpfa_pkg::STAT_NO_ROOM, result_address: '0};
                    state_next = bpfa_pkg::ST_IDLE;
                end
                else
                begin
                    run_next = sc_run_out;
                    if (sc_has_used)
                    begin
                        if (sc_last_used == IW'(W - 1))
                        begin
                            rsw_next      = cur_w_reg + AW'(1);
                            rsw_base_next = base_end;
                        end
                        else
                        begin
                            rsw_next      = cur_w_reg;
                            rsw_base_next = base_reg;
                        end
                    end
                    cur_w_next = cur_w_reg + AW'(1);
                    base_next  = base_end;
                    re         = 1'b1;
                end
            end
            bpfa_pkg::ST_CHECK:
            begin
                if (s_in_word)
                begin
                    rsw_next      = cur_w_reg;
                    rsw_base_next = base_reg;
                end
                if ((rd_data & rng_mask) != '0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{status: bpfa_pkg::STAT_USED, result_address: '0};
                    state_next = bpfa_pkg::ST_IDLE;
                end
                else if (base_end >= e_reg)
                begin
                    cur_w_next = s_in_word ? cur_w_reg : rsw_reg;
                    base_next  = s_in_word ? base_reg : rsw_base_reg;
                    re         = 1'b1;
                    state_next = bpfa_pkg::ST_MARK;
                end
                else
                begin
                    cur_w_next = cur_w_reg + AW'(1);
                    base_next  = base_end;
                    re         = 1'b1;
                end
            end
            bpfa_pkg::ST_MARK:
            begin
                we    = 1'b1;
                wdata = rd_data | rng_mask;
                if (base_end >= e_reg)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{status: bpfa_pkg::STAT_OK, result_address: s_wide[AD-1:0]};
                    state_next = bpfa_pkg::ST_IDLE;
                end
                else
                begin
                    cur_w_next = cur_w_reg + AW'(1);
                    base_next  = base_end;
                    re         = 1'b1;
                end
            end
            bpfa_pkg::ST_FREE:
            begin
                if (rng_mask != '0)
                begin
                    done_next  = 1'b1;
                    state_next = bpfa_pkg::ST_IDLE;
                    if ((rd_data & rng_mask) != '0)
                    begin
                        we       = 1'b1;
                        wdata    = rd_data & ~rng_mask;
                        rsp_next = '{status: bpfa_pkg::STAT_OK, result_address: '0};
                    end
                    else
                    begin
                        rsp_next = '{status: bpfa_pkg::STAT_WAS_FREE, result_address: '0};
                    end
                end
                else
                begin
                    cur_w_next = cur_w_reg + AW'(1);
                    base_next  = base_end;
                    re         = 1'b1;
                end
            end
            default:
            begin
                state_next = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != bpfa_pkg::ST_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule
